// ===== rtl/core/pad_autorepeat_grid_cursor_top_macros.svh =====
// Assertion macros for the pad auto-repeat grid cursor block.
// Used by the checker module; expects clk and rst_n in the enclosing scope.
`ifndef PAD_AUTOREPEAT_GRID_CURSOR_TOP_MACROS_SVH
`define PAD_AUTOREPEAT_GRID_CURSOR_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define PAGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PAGC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pagc_pkg.sv =====
// Shared types, constants and the character table of the grid cursor block.
// No dependencies; the channel, control, top and checker files import this package.
package pagc_pkg;

  localparam int GRID_COLS      = 10;
  localparam int GRID_ROWS      = 4;
  localparam int NUM_CHANNELS   = 5;
  localparam int TEXT_CAPACITY  = 255;
  localparam int TEXT_CAP_EFF   = (TEXT_CAPACITY < 255) ? TEXT_CAPACITY : 255;
  localparam int TIME_W         = 32;
  localparam int DELAY_W        = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 2;

  localparam logic [15:0] RESET_INITIAL_DELAY = 16'd1000;
  localparam logic [15:0] RESET_REPEAT_DELAY  = 16'd300;
  localparam logic        RESET_CHAR_SET      = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAR_SET     = 2'd0,
    CFG_INIT_DELAY   = 2'd1,
    CFG_REPEAT_DELAY = 2'd2
  } pagc_cfg_idx_t;

  typedef struct packed {
    logic              pad_present;
    logic              key_right;
    logic              key_left;
    logic              key_up;
    logic              key_down;
    logic              key_select;
    logic              key_start;
    logic [TIME_W-1:0] now_ms;
  } pagc_in_item_t;

  typedef struct packed {
    logic [3:0] cursor_col;
    logic [1:0] cursor_row;
    logic       char_valid;
    logic [7:0] char_code;
    logic [7:0] char_index;
    logic [7:0] text_length;
    logic       finished;
  } pagc_out_item_t;

  // Fire results of the five typematic channels
  typedef struct packed {
    logic right;
    logic left;
    logic up;
    logic down;
    logic sel;
  } pagc_fire_t;

  // Update enables from the control logic to the channels
  typedef struct packed {
    logic move_en;
    logic sel_en;
  } pagc_upd_t;

  // Character table: set 0 symbols/uppercase, set 1 digits/lowercase
  localparam logic [7:0] CHAR_ROM [0:79] = '{
    8'h21, 8'h22, 8'hB7, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28, 8'h29, 8'h3D,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hD1,
    8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F,
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hF1,
    8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D
  };

  // Look up the character under the cursor; out-of-grid columns read column 0
  function automatic logic [7:0] char_lookup(input logic set, input logic [1:0] row,
                                             input logic [3:0] col);
    logic [3:0] c;
    logic [6:0] idx;
    c   = (col < 4'(GRID_COLS)) ? col : 4'd0;
    idx = 7'(set) * 7'(GRID_ROWS * GRID_COLS) + 7'(row) * 7'(GRID_COLS) + 7'(c);
    return CHAR_ROM[idx];
  endfunction

endpackage

// ===== rtl/core/pagc_stream_if.sv =====
// Valid/ready stream interface carrying one item of payload type T.
// Used for the sample and result channels; no package dependency.
interface pagc_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pagc_channel.sv =====
// One typematic auto-repeat channel: press tracking, delay select, fire.
// Depends on pagc_pkg.
module pagc_channel
  import pagc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd_en,
  input  logic               level,
  input  logic [TIME_W-1:0]  now_ms,
  input  logic [DELAY_W-1:0] initial_delay,
  input  logic [DELAY_W-1:0] repeat_delay,
  output logic               fire
);

  logic              held_r, held_nxt;
  logic              use_rep_r, use_rep_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [TIME_W-1:0] elapsed;
  logic [DELAY_W-1:0] delay;

  // Fire on a fresh press, or once the delay in force has passed
  always_comb begin
    elapsed = (now_ms >= last_r) ? (now_ms - last_r) : (last_r - now_ms);
    delay   = use_rep_r ? repeat_delay : initial_delay;
    fire    = level && (!held_r || (elapsed >= TIME_W'(delay)));
  end

  // Update press and timing state
  always_comb begin
    held_nxt    = held_r;
    use_rep_nxt = use_rep_r;
    last_nxt    = last_r;
    if (upd_en) begin
      if (!level) begin
        held_nxt = 1'b0;
      end else if (fire) begin
        if (!held_r) begin
          held_nxt    = 1'b1;
          use_rep_nxt = 1'b0;
        end else begin
          use_rep_nxt = 1'b1;
        end
        last_nxt = now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 1'b0;
      use_rep_r <= 1'b0;
      last_r    <= '0;
    end else begin
      held_r    <= held_nxt;
      use_rep_r <= use_rep_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

// ===== rtl/core/pagc_ctrl.sv =====
// Cursor, text count and finish logic; builds the result of each sample.
// Depends on pagc_pkg.
module pagc_ctrl
  import pagc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic           pad_present,
  input  logic           key_start,
  input  logic           char_set,
  input  pagc_fire_t     fire,
  output pagc_upd_t      upd,
  output pagc_out_item_t result
);

  logic [3:0] col_r, col_nxt;
  logic [1:0] row_r, row_nxt;
  logic [7:0] count_r, count_nxt;
  logic       done_r, done_nxt;
  logic       step;
  logic       aborted;

  // Apply one sample: append, move, finish
  always_comb begin
    step      = accept && pad_present && !done_r;
    aborted   = fire.sel && (count_r >= 8'(TEXT_CAP_EFF));
    col_nxt   = col_r;
    row_nxt   = row_r;
    count_nxt = count_r;
    done_nxt  = done_r;
    result.char_valid = 1'b0;
    result.char_code  = 8'd0;
    result.char_index = 8'd0;
    if (step && !aborted) begin
      if (fire.sel) begin
        result.char_valid = 1'b1;
        result.char_code  = char_lookup(char_set, row_r, col_r);
        result.char_index = count_r;
        count_nxt         = count_r + 8'd1;
      end
      if (key_start) begin
        done_nxt = 1'b1;
      end
      // left wins over right
      if (fire.left) begin
        col_nxt = (col_r == 4'd0) ? 4'(GRID_COLS - 1) : col_r - 4'd1;
      end else if (fire.right) begin
        col_nxt = (col_r >= 4'(GRID_COLS - 1)) ? 4'd0 : col_r + 4'd1;
      end
      // down wins over up
      if (fire.down) begin
        row_nxt = (row_r == 2'(GRID_ROWS - 1)) ? 2'd0 : row_r + 2'd1;
      end else if (fire.up) begin
        row_nxt = (row_r == 2'd0) ? 2'(GRID_ROWS - 1) : row_r - 2'd1;
      end
    end
    upd.move_en        = step;
    upd.sel_en         = step && !aborted;
    result.cursor_col  = col_nxt;
    result.cursor_row  = row_nxt;
    result.text_length = count_nxt;
    result.finished    = done_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

// ===== rtl/core/pad_autorepeat_grid_cursor_top.sv =====
// Pad auto-repeat grid cursor: top level with config registers and result register.
// Depends on pagc_pkg, pagc_stream_if, pagc_channel and pagc_ctrl.
//
// Usage:
//   in_ch carries one pad sample per item (pad present, six button levels, time in ms).
//   out_ch returns exactly one result item per sample: cursor position, the character
//   appended (if any), its store index, the text length and the finished flag.
//   cfg_we/cfg_index/cfg_wdata write char_set (0), initial delay (1), repeat delay (2);
//   write them only while no sample is in flight.
// Each result is registered and presented in the cycle after its sample is accepted.
// Throughput: one sample per cycle while out_ch is not stalled; all channel, cursor and lookup logic settles
//   between the channel state registers and the single result register.
// Reset (rst_n low at a clock edge): cursor at column 0 row 0, text empty, not
//   finished, all buttons released, char_set 1, delays 1000 ms and 300 ms.
// Stall: while out_ch.ready is low a pending result holds; in_ch.ready drops only
//   when the result register is full and not being emptied that cycle.
module pad_autorepeat_grid_cursor_top
  import pagc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  pagc_stream_if.sink          in_ch,
  pagc_stream_if.source        out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic               char_set_r;
  logic [DELAY_W-1:0] init_delay_r;
  logic [DELAY_W-1:0] rep_delay_r;
  logic               out_valid_r;
  pagc_out_item_t     out_data_r;
  pagc_in_item_t      sample;
  pagc_out_item_t     result;
  pagc_fire_t         fire;
  pagc_upd_t          upd;
  logic               accept;
  logic [NUM_CHANNELS-1:0] levels;
  logic [NUM_CHANNELS-1:0] fires;
  logic [NUM_CHANNELS-1:0] upd_en;

  assign sample       = in_ch.data;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_set_r   <= RESET_CHAR_SET;
      init_delay_r <= RESET_INITIAL_DELAY;
      rep_delay_r  <= RESET_REPEAT_DELAY;
    end else if (cfg_we) begin
      unique case (pagc_cfg_idx_t'(cfg_index))
        CFG_CHAR_SET:     char_set_r   <= cfg_wdata[0];
        CFG_INIT_DELAY:   init_delay_r <= cfg_wdata[DELAY_W-1:0];
        CFG_REPEAT_DELAY: rep_delay_r  <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel order: right, left, up, down, select
  assign levels = {sample.key_right, sample.key_left, sample.key_up,
                   sample.key_down, sample.key_select};
  assign upd_en = {{(NUM_CHANNELS-1){upd.move_en}}, upd.sel_en};
  assign fire   = pagc_fire_t'(fires);

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    pagc_channel u_chan (
      .clk           (clk),
      .rst_n         (rst_n),
      .upd_en        (upd_en[i]),
      .level         (levels[i]),
      .now_ms        (sample.now_ms),
      .initial_delay (init_delay_r),
      .repeat_delay  (rep_delay_r),
      .fire          (fires[i])
    );
  end

  pagc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pad_present (sample.pad_present),
    .key_start   (sample.key_start),
    .char_set    (char_set_r),
    .fire        (fire),
    .upd         (upd),
    .result      (result)
  );

  // Hold the result until taken; load a new one on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

endmodule

// ===== rtl/core/pagc_checker.sv =====
// Port-level checks for the grid cursor top level, attached by bind.
// Depends on pagc_pkg and the assertion macro header.
`include "pad_autorepeat_grid_cursor_top_macros.svh"

module pagc_checker
  import pagc_pkg::*;
(
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input pagc_out_item_t out_data
);

  // A pending result stays offered until taken
  `PAGC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // An appended character sits just below the new text length
  `PAGC_ASSERT(a_char_index, out_valid && out_data.char_valid |-> out_data.text_length == out_data.char_index + 8'd1, "char index does not match text length")

  // No character means zero code and index
  `PAGC_ASSERT(a_no_char, out_valid && !out_data.char_valid |-> out_data.char_code == 8'd0 && out_data.char_index == 8'd0, "stale character fields")

  // Column stays on the grid
  `PAGC_ASSERT(a_col_range, out_valid |-> out_data.cursor_col < 4'(GRID_COLS), "cursor column off grid")

  // Nothing is offered during reset
  `PAGC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind pad_autorepeat_grid_cursor_top pagc_checker u_pagc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
